### design/cafl_pkg.sv
// Shared types and codes for the 8/16-bit flag-producing ALU.
// Holds the operation codes, flag bit positions and beat structs.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cafl_pkg;

    // Operation codes
    localparam logic [4:0] OP_INC8  = 5'd0;
    localparam logic [4:0] OP_DEC8  = 5'd1;
    localparam logic [4:0] OP_INC16 = 5'd2;
    localparam logic [4:0] OP_DEC16 = 5'd3;
    localparam logic [4:0] OP_INCW  = 5'd4;
    localparam logic [4:0] OP_DECW  = 5'd5;
    localparam logic [4:0] OP_ADD8  = 5'd6;
    localparam logic [4:0] OP_ADC8  = 5'd7;
    localparam logic [4:0] OP_SUB8  = 5'd8;
    localparam logic [4:0] OP_SBC8  = 5'd9;
    localparam logic [4:0] OP_AND8  = 5'd10;
    localparam logic [4:0] OP_XOR8  = 5'd11;
    localparam logic [4:0] OP_OR8   = 5'd12;
    localparam logic [4:0] OP_CP8   = 5'd13;
    localparam logic [4:0] OP_ADD16 = 5'd14;
    localparam logic [4:0] OP_ADC16 = 5'd15;
    localparam logic [4:0] OP_SUB16 = 5'd16;
    localparam logic [4:0] OP_SBC16 = 5'd17;
    localparam logic [4:0] OP_AND16 = 5'd18;
    localparam logic [4:0] OP_XOR16 = 5'd19;
    localparam logic [4:0] OP_OR16  = 5'd20;

    // Flag byte bit positions, S Z I H X V N C from bit 7 down
    localparam int FLAG_S = 7;
    localparam int FLAG_Z = 6;
    localparam int FLAG_I = 5;
    localparam int FLAG_H = 4;
    localparam int FLAG_X = 3;
    localparam int FLAG_V = 2;
    localparam int FLAG_N = 1;
    localparam int FLAG_C = 0;

    // Beat widths on the stream ports
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic [7:0]  flags_in;
        logic [15:0] right_operand;
        logic [15:0] left_operand;
        logic [4:0]  req_type;
    } req_t;

    typedef struct packed {
        logic        write_back;
        logic [7:0]  flags_out;
        logic [15:0] result_value;
    } res_t;

endpackage

`default_nettype wire

### design/cafl_in_stage.sv
// Input register of the ALU: captures one request beat per cycle while s_axis_tready is high.
// Depends on cafl_pkg for the request struct and beat width.
`timescale 1ns / 1ps
`default_nettype none

module cafl_in_stage (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] req_type, [20:5] left_operand, [36:21] right_operand,
    // [44:37] flags_in, [47:45] zero
    input  wire logic [cafl_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output cafl_pkg::req_t                      req,
    output logic                                req_valid,
    input  wire logic                           req_take
);
    import cafl_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    // Accept when empty or when the held beat moves on this cycle
    assign s_axis_tready = !valid_reg || req_take;
    assign valid_next    = s_axis_tvalid || (valid_reg && !req_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on every accepted beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg <= req_t'(s_axis_tdata[$bits(req_t)-1:0]);
        end
    end

    assign req       = req_reg;
    assign req_valid = valid_reg;

endmodule

`default_nettype wire

### design/cafl_core.sv
// Combinational ALU datapath: result, new flags and write-back mark.
// Depends on cafl_pkg for operation codes, flag positions and structs.
`timescale 1ns / 1ps
`default_nettype none

module cafl_core (
    input  wire cafl_pkg::req_t req,
    output cafl_pkg::res_t      res
);
    import cafl_pkg::*;

    logic [7:0]  a8, b8, bx8, r8, inc8, dec8, lr8, fi;
    logic [15:0] a16, b16, bx16, r16, inc16, dec16, lr16;
    logic [8:0]  sum8;
    logic [4:0]  half8;
    logic [16:0] sum16;
    logic [12:0] half16;
    logic        sub8, sub16, ci8, ci16, cin;
    logic        c8, h8, v8, c16, h16, v16;
    logic [7:0]  af8, af16, lf8, lf16;
    logic [4:0]  op;

    assign op  = req.req_type;
    assign a8  = req.left_operand[7:0];
    assign b8  = req.right_operand[7:0];
    assign a16 = req.left_operand;
    assign b16 = req.right_operand;
    assign fi  = req.flags_in;
    assign cin = fi[FLAG_C];

    // 8-bit adder, subtract as add of inverted operand
    assign sub8 = (op == OP_SUB8) || (op == OP_SBC8) || (op == OP_CP8);
    assign ci8  = (((op == OP_ADC8) || (op == OP_SBC8)) ? cin : 1'b0) ^ sub8;
    assign bx8  = sub8 ? ~b8 : b8;
    assign sum8  = {1'b0, a8} + {1'b0, bx8} + {8'd0, ci8};
    assign half8 = {1'b0, a8[3:0]} + {1'b0, bx8[3:0]} + {4'd0, ci8};
    assign r8 = sum8[7:0];
    assign c8 = sum8[8] ^ sub8;
    assign h8 = half8[4] ^ sub8;
    assign v8 = ~(a8[7] ^ bx8[7]) & (a8[7] ^ r8[7]);
    assign af8 = {r8[7], r8 == 8'd0, fi[FLAG_I], h8, c8, v8, sub8, c8};

    // 16-bit adder, half carry out of bit 11
    assign sub16 = (op == OP_SUB16) || (op == OP_SBC16);
    assign ci16  = (((op == OP_ADC16) || (op == OP_SBC16)) ? cin : 1'b0) ^ sub16;
    assign bx16  = sub16 ? ~b16 : b16;
    assign sum16  = {1'b0, a16} + {1'b0, bx16} + {16'd0, ci16};
    assign half16 = {1'b0, a16[11:0]} + {1'b0, bx16[11:0]} + {12'd0, ci16};
    assign r16 = sum16[15:0];
    assign c16 = sum16[16] ^ sub16;
    assign h16 = half16[12] ^ sub16;
    assign v16 = ~(a16[15] ^ bx16[15]) & (a16[15] ^ r16[15]);
    assign af16 = {r16[15], r16 == 16'd0, fi[FLAG_I], h16, c16, v16, sub16, c16};

    // Logic ops; parity flag (8-bit forms only) is set for an even count of ones
    always_comb
    begin
        case (op)
            OP_AND8:  lr8 = a8 & b8;
            OP_XOR8:  lr8 = a8 ^ b8;
            default:  lr8 = a8 | b8;
        endcase
        case (op)
            OP_AND16: lr16 = a16 & b16;
            OP_XOR16: lr16 = a16 ^ b16;
            default:  lr16 = a16 | b16;
        endcase
    end
    assign lf8  = {lr8[7], lr8 == 8'd0, fi[FLAG_I], op == OP_AND8, 1'b0, ~^lr8,
                   1'b0, 1'b0};
    assign lf16 = {lr16[15], lr16 == 16'd0, fi[FLAG_I], op == OP_AND16, 1'b0, 1'b0,
                   1'b0, 1'b0};

    // Increment and decrement
    assign inc8  = a8 + 8'd1;
    assign dec8  = a8 - 8'd1;
    assign inc16 = a16 + 16'd1;
    assign dec16 = a16 - 16'd1;

    // Select result by operation
    always_comb
    begin
        res.result_value = a16;
        res.flags_out    = fi;
        res.write_back   = 1'b1;
        case (op)
            OP_INC8:
            begin
                res.result_value = {8'd0, inc8};
                res.flags_out = {inc8[7], inc8 == 8'd0, fi[FLAG_I], inc8[3:0] == 4'd0,
                                 inc8 == 8'd0, a8 == 8'h7f, 1'b0, fi[FLAG_C]};
            end
            OP_DEC8:
            begin
                res.result_value = {8'd0, dec8};
                res.flags_out = {dec8[7], dec8 == 8'd0, fi[FLAG_I], a8[3:0] == 4'd0,
                                 a8 == 8'd0, a8 == 8'h80, 1'b1, fi[FLAG_C]};
            end
            OP_INC16:
            begin
                res.result_value = inc16;
                res.flags_out = fi;
                res.flags_out[FLAG_X] = (inc16 == 16'd0);
            end
            OP_DEC16:
            begin
                res.result_value = dec16;
                res.flags_out = fi;
                res.flags_out[FLAG_X] = (dec16 == 16'hffff);
            end
            OP_INCW:
            begin
                res.result_value = inc16;
                res.flags_out = {inc16[15], inc16 == 16'd0, fi[FLAG_I], fi[FLAG_H],
                                 inc16 == 16'd0, a16 == 16'h7fff, 1'b0, fi[FLAG_C]};
            end
            OP_DECW:
            begin
                res.result_value = dec16;
                res.flags_out = {dec16[15], dec16 == 16'd0, fi[FLAG_I], fi[FLAG_H],
                                 a16 == 16'd0, a16 == 16'h8000, 1'b1, fi[FLAG_C]};
            end
            OP_ADD8, OP_ADC8, OP_SUB8, OP_SBC8:
            begin
                res.result_value = {8'd0, r8};
                res.flags_out = af8;
            end
            OP_CP8:
            begin
                res.result_value = {8'd0, r8};
                res.flags_out = af8;
                res.write_back = 1'b0;
            end
            OP_AND8, OP_XOR8, OP_OR8:
            begin
                res.result_value = {8'd0, lr8};
                res.flags_out = lf8;
            end
            OP_ADD16, OP_ADC16, OP_SUB16, OP_SBC16:
            begin
                res.result_value = r16;
                res.flags_out = af16;
            end
            OP_AND16, OP_XOR16, OP_OR16:
            begin
                res.result_value = lr16;
                res.flags_out = lf16;
            end
            default:
            begin
                // Unused code: pass operand and flags, no write-back
                res.result_value = a16;
                res.flags_out = fi;
                res.write_back = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/cafl_out_stage.sv
// Result register of the ALU: holds one result beat until taken.
// Depends on cafl_pkg for the result struct and beat width.
`timescale 1ns / 1ps
`default_nettype none

module cafl_out_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cafl_pkg::res_t            res,
    input  wire logic                      res_valid,
    output logic                           res_take,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [15:0] result_value, [23:16] flags_out, [24] write_back, [31:25] zero
    output logic [cafl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cafl_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // Load when empty or when the held beat leaves this cycle
    assign res_take = res_valid && (!valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_axis_tready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule

`default_nettype wire

### design/cpu_alu_8_16_flags.sv
// Top level of the 8/16-bit flag-producing ALU.
// Depends on cafl_pkg, cafl_in_stage, cafl_core and cafl_out_stage.
//
//  Channel   Dir  Beat content (low bit up)
//  s_axis    in   req_type, left_operand, right_operand, flags_in
//  m_axis    out  result_value, flags_out, write_back
//
// One request per cycle while m_axis is not stalled; each taken beat passes
// through the input register, one pass of the ALU logic and the result register.
// rst_n clears both stage valid bits asynchronously; payload is not reset.
// A stall on m_axis holds the result register; an empty input register
// still takes one beat, then s_axis_tready stays low until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_8_16_flags (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] req_type, [20:5] left_operand, [36:21] right_operand,
    // [44:37] flags_in, [47:45] zero
    input  wire logic [cafl_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] result_value, [23:16] flags_out, [24] write_back, [31:25] zero
    output logic [cafl_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import cafl_pkg::*;

    req_t req;
    res_t res;
    logic req_valid;
    logic req_take;

    // Register the request beat
    cafl_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .req           (req),
        .req_valid     (req_valid),
        .req_take      (req_take)
    );

    // Compute result and flags
    cafl_core u_core (
        .req (req),
        .res (res)
    );

    // Register and hand off the result beat
    cafl_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .res_valid     (req_valid),
        .res_take      (req_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### design/cafl_checker.sv
// Port-level checks for the ALU top level, attached by bind.
// Depends on cafl_pkg for beat widths and on cpu_alu_8_16_flags.
`timescale 1ns / 1ps
`default_nettype none

module cafl_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [cafl_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cafl_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // Empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    // Input blocks only behind a stalled result
    a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output stall");

    // Each fresh result beat is preceded by a taken request beat
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result beat without request beat");

    // Padding bits of the result beat stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:25] == '0)
        else $error("result padding not zero");

endmodule

bind cpu_alu_8_16_flags cafl_checker u_cafl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for cpu_alu_8_16_flags: streams requests, predicts each result.
// Depends on cafl_pkg and the cpu_alu_8_16_flags design; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import cafl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BLOCKS  = 16;
    localparam int BLOCK_ITEMS    = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic                 m_ready = 1'b0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire  [M_TDATA_W-1:0] m_axis_tdata;

    res_t predicted_results[$];
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    int   src_gap_max = 0;
    int   snk_gap_max = 0;
    bit   snk_hold_req = 1'b0;

    cpu_alu_8_16_flags DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Add or subtract at 8 or 16 bits with carry/borrow, half carry and overflow
    function automatic void arith_flags(input logic [15:0] a, input logic [15:0] b,
                                        input logic cin, input logic sub, input logic wide,
                                        input logic [7:0] f, output logic [15:0] r,
                                        output logic [7:0] fl);
        logic [16:0] full;
        logic [12:0] half;
        logic [15:0] aw, bw;
        logic [11:0] ah, bh;
        logic        co, hc, sa, sb, sr;
        aw = wide ? a : {8'h00, a[7:0]};
        bw = wide ? b : {8'h00, b[7:0]};
        ah = wide ? a[11:0] : {8'h00, a[3:0]};
        bh = wide ? b[11:0] : {8'h00, b[3:0]};
        full = sub ? ({1'b0, aw} - {1'b0, bw} - cin) : ({1'b0, aw} + {1'b0, bw} + cin);
        half = sub ? ({1'b0, ah} - {1'b0, bh} - cin) : ({1'b0, ah} + {1'b0, bh} + cin);
        r  = wide ? full[15:0] : {8'h00, full[7:0]};
        co = wide ? full[16] : full[8];
        hc = wide ? half[12] : half[4];
        sa = wide ? aw[15] : aw[7];
        sb = wide ? bw[15] : bw[7];
        sr = wide ? r[15] : r[7];
        fl = '0;
        fl[FLAG_I] = f[FLAG_I];
        fl[FLAG_N] = sub;
        fl[FLAG_S] = sr;
        fl[FLAG_Z] = (r == 16'h0000);
        fl[FLAG_H] = hc;
        fl[FLAG_X] = co;
        fl[FLAG_C] = co;
        fl[FLAG_V] = sub ? ((sa != sb) && (sr != sa)) : ((sa == sb) && (sr != sa));
    endfunction

    // Flags of AND / XOR / OR; parity only on the 8-bit forms
    function automatic logic [7:0] bitwise_flags(input logic [15:0] r, input logic wide,
                                                 input logic is_and, input logic [7:0] f);
        logic [7:0] fl;
        fl = '0;
        fl[FLAG_I] = f[FLAG_I];
        fl[FLAG_S] = wide ? r[15] : r[7];
        fl[FLAG_Z] = (r == 16'h0000);
        fl[FLAG_H] = is_and;
        fl[FLAG_V] = !wide && !(^r[7:0]);
        return fl;
    endfunction

    // Expected result, new flags and write-back mark of one request
    function automatic res_t alu_predict(input req_t q);
        res_t        p;
        logic [15:0] a, b, r;
        logic [7:0]  a8, b8, f, fl;
        logic        cin;
        a   = q.left_operand;
        b   = q.right_operand;
        a8  = a[7:0];
        b8  = b[7:0];
        f   = q.flags_in;
        cin = f[FLAG_C];
        r   = a;
        fl  = f;
        p.write_back = 1'b1;
        case (q.req_type)
            OP_INC8:
            begin
                r = {8'h00, a8 + 8'h01};
                fl = '0;
                fl[FLAG_I] = f[FLAG_I];
                fl[FLAG_C] = f[FLAG_C];
                fl[FLAG_S] = r[7];
                fl[FLAG_Z] = (r[7:0] == 8'h00);
                fl[FLAG_X] = (r[7:0] == 8'h00);
                fl[FLAG_H] = (r[3:0] == 4'h0);
                fl[FLAG_V] = (a8 == 8'h7f);
            end
            OP_DEC8:
            begin
                r = {8'h00, a8 - 8'h01};
                fl = '0;
                fl[FLAG_I] = f[FLAG_I];
                fl[FLAG_C] = f[FLAG_C];
                fl[FLAG_N] = 1'b1;
                fl[FLAG_S] = r[7];
                fl[FLAG_Z] = (r[7:0] == 8'h00);
                fl[FLAG_X] = (a8 == 8'h00);
                fl[FLAG_H] = (a8[3:0] == 4'h0);
                fl[FLAG_V] = (a8 == 8'h80);
            end
            OP_INC16:
            begin
                r = a + 16'h0001;
                fl[FLAG_X] = (r == 16'h0000);
            end
            OP_DEC16:
            begin
                r = a - 16'h0001;
                fl[FLAG_X] = (r == 16'hffff);
            end
            OP_INCW, OP_DECW:
            begin
                fl = '0;
                fl[FLAG_I] = f[FLAG_I];
                fl[FLAG_H] = f[FLAG_H];
                fl[FLAG_C] = f[FLAG_C];
                if (q.req_type == OP_INCW)
                begin
                    r = a + 16'h0001;
                    fl[FLAG_X] = (r == 16'h0000);
                    fl[FLAG_V] = (a == 16'h7fff);
                end
                else
                begin
                    r = a - 16'h0001;
                    fl[FLAG_N] = 1'b1;
                    fl[FLAG_X] = (a == 16'h0000);
                    fl[FLAG_V] = (a == 16'h8000);
                end
                fl[FLAG_S] = r[15];
                fl[FLAG_Z] = (r == 16'h0000);
            end
            OP_ADD8:  arith_flags(a, b, 1'b0, 1'b0, 1'b0, f, r, fl);
            OP_ADC8:  arith_flags(a, b, cin,  1'b0, 1'b0, f, r, fl);
            OP_SUB8:  arith_flags(a, b, 1'b0, 1'b1, 1'b0, f, r, fl);
            OP_SBC8:  arith_flags(a, b, cin,  1'b1, 1'b0, f, r, fl);
            OP_CP8:
            begin
                arith_flags(a, b, 1'b0, 1'b1, 1'b0, f, r, fl);
                p.write_back = 1'b0;
            end
            OP_AND8:
            begin
                r = {8'h00, a8 & b8};
                fl = bitwise_flags(r, 1'b0, 1'b1, f);
            end
            OP_XOR8:
            begin
                r = {8'h00, a8 ^ b8};
                fl = bitwise_flags(r, 1'b0, 1'b0, f);
            end
            OP_OR8:
            begin
                r = {8'h00, a8 | b8};
                fl = bitwise_flags(r, 1'b0, 1'b0, f);
            end
            OP_ADD16: arith_flags(a, b, 1'b0, 1'b0, 1'b1, f, r, fl);
            OP_ADC16: arith_flags(a, b, cin,  1'b0, 1'b1, f, r, fl);
            OP_SUB16: arith_flags(a, b, 1'b0, 1'b1, 1'b1, f, r, fl);
            OP_SBC16: arith_flags(a, b, cin,  1'b1, 1'b1, f, r, fl);
            OP_AND16:
            begin
                r = a & b;
                fl = bitwise_flags(r, 1'b1, 1'b1, f);
            end
            OP_XOR16:
            begin
                r = a ^ b;
                fl = bitwise_flags(r, 1'b1, 1'b0, f);
            end
            OP_OR16:
            begin
                r = a | b;
                fl = bitwise_flags(r, 1'b1, 1'b0, f);
            end
            default:
            begin
                // unused code: pass operand and flags through, no write-back
                r = a;
                fl = f;
                p.write_back = 1'b0;
            end
        endcase
        p.result_value = r;
        p.flags_out    = fl;
        return p;
    endfunction

    // Offer one request beat after a random gap; record its prediction when taken
    task automatic send_request(input logic [4:0] op, input logic [15:0] lhs,
                                input logic [15:0] rhs, input logic [7:0] fl);
        req_t q;
        int   gap;
        q.req_type      = op;
        q.left_operand  = lhs;
        q.right_operand = rhs;
        q.flags_in      = fl;
        gap = $urandom_range(0, src_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            s_data  <= S_TDATA_W'({$urandom, $urandom});
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {3'b000, q};
        do @(posedge clk); while (!s_axis_tready);
        predicted_results.push_back(alu_predict(q));
    endtask

    function automatic logic [4:0] pick_op();
        if ($urandom_range(0, 9) == 0)
            return 5'($urandom_range(OP_OR16 + 1, 31));
        return 5'($urandom_range(0, OP_OR16));
    endfunction

    // Favor the sign, carry and wrap boundaries over plain random values
    function automatic logic [15:0] pick_operand();
        logic [7:0] hi, lo;
        hi = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       lo = 8'h00;
            1:       lo = 8'h7f;
            2:       lo = 8'h80;
            default: lo = 8'hff;
        endcase
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h7fff;
            3:       return 16'h8000;
            4, 5:    return {hi, lo};
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(pick_op(), pick_operand(), pick_operand(),
                         8'($urandom_range(0, 255)));
    endtask

    // Increment and decrement forms at their wrap and overflow points
    task automatic test_inc_dec();
        send_request(OP_INC8,  16'hab7f, 16'h0000, 8'h00);
        send_request(OP_INC8,  16'h12ff, 16'hffff, 8'hff);
        send_request(OP_DEC8,  16'h0080, 16'h0000, 8'h00);
        send_request(OP_DEC8,  16'hff00, 16'h0000, 8'hff);
        send_request(OP_INC16, 16'hffff, 16'h0000, 8'h00);
        send_request(OP_DEC16, 16'h0000, 16'h0000, 8'hf7);
        send_request(OP_INCW,  16'h7fff, 16'h0000, 8'hff);
        send_request(OP_INCW,  16'hffff, 16'h0000, 8'h00);
        send_request(OP_DECW,  16'h8000, 16'h0000, 8'h00);
        send_request(OP_DECW,  16'h0000, 16'h0000, 8'hff);
    endtask

    // Every two-operand operation, some with carry in and stale flags set
    task automatic test_arith_logic();
        send_request(OP_ADD8,  16'h55ff, 16'haa01, 8'h00);
        send_request(OP_ADC8,  16'h007f, 16'h0000, 8'h01);
        send_request(OP_SUB8,  16'hff00, 16'h0001, 8'h00);
        send_request(OP_SBC8,  16'h0080, 16'h007f, 8'hff);
        send_request(OP_AND8,  16'h00ff, 16'hffff, 8'hde);
        send_request(OP_XOR8,  16'h33a5, 16'hcca5, 8'hff);
        send_request(OP_OR8,   16'h0000, 16'hff00, 8'hff);
        send_request(OP_CP8,   16'h1242, 16'h3442, 8'h00);
        send_request(OP_ADD16, 16'hffff, 16'h0001, 8'h00);
        send_request(OP_ADC16, 16'h7fff, 16'h0000, 8'h01);
        send_request(OP_SUB16, 16'h0000, 16'hffff, 8'h00);
        send_request(OP_SBC16, 16'h8000, 16'h0000, 8'hff);
        send_request(OP_AND16, 16'h8000, 16'hffff, 8'hff);
        send_request(OP_XOR16, 16'hffff, 16'hffff, 8'h00);
        send_request(OP_OR16,  16'h8001, 16'h7ffe, 8'hff);
    endtask

    // Undefined operation codes pass through
    task automatic test_unused_codes();
        send_request(OP_OR16 + 5'd1, 16'hbeef, 16'h1234, 8'h5a);
        send_request(5'd31,          16'h0000, 16'hffff, 8'hff);
    endtask

    // Random requests in blocks, each with its own idle pattern on both sides
    task automatic test_random();
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            case (blk % 5)
                0:
                begin
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                1:
                begin
                    src_gap_max = 11;
                    snk_gap_max = 0;
                end
                2:
                begin
                    src_gap_max = 0;
                    snk_gap_max = 11;
                end
                3:
                begin
                    src_gap_max = 11;
                    snk_gap_max = 11;
                end
                default:
                begin
                    src_gap_max = $urandom_range(0, 11);
                    snk_gap_max = $urandom_range(0, 11);
                end
            endcase
            send_random(BLOCK_ITEMS);
        end
    endtask

    // Stall the result side for a long stretch while requests keep coming
    task automatic test_backpressure();
        src_gap_max  = 0;
        snk_gap_max  = 0;
        snk_hold_req = 1'b1;
        send_random(40);
    endtask

    // Result side ready pattern: random gap per beat, or a long hold on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (snk_hold_req)
            begin
                snk_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                gap = $urandom_range(0, snk_gap_max);
                if (gap > 0)
                begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        res_t       got;
        res_t       want;
        logic [6:0] pad;
        if (rst_n && m_axis_tvalid && m_ready)
        begin
            got = m_axis_tdata[24:0];
            pad = m_axis_tdata[31:25];
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result beat %h", m_axis_tdata);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.result_value !== want.result_value || got.flags_out !== want.flags_out
                    || got.write_back !== want.write_back || pad !== 7'd0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result exp %h/%h/%b got %h/%h/%b pad %h",
                                 want.result_value, want.flags_out, want.write_back,
                                 got.result_value, got.flags_out, got.write_back, pad);
                end
            end
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_inc_dec();
        test_arith_logic();
        test_unused_codes();
        test_random();
        test_backpressure();

        // drop valid, drain outstanding results, then watch for strays
        @(negedge clk);
        s_valid <= 1'b0;
        snk_gap_max = 0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
